// File: sv/cpu_alu_with_flags_core_macros.svh
// Assertion macros shared by the checker files of the ALU core.
`ifndef CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Property checked at every rising edge, abandoned while reset is held.
`define CAWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define CAWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cawf_pkg.sv
`timescale 1ns / 1ps

package cawf_pkg;

  // Channel widths.
  localparam int FUNC_W      = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_SRL   = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_DAA   = 5'd21,
    OP_CPL   = 5'd22,
    OP_SCF   = 5'd23,
    OP_CCF   = 5'd24,
    OP_RLCA  = 5'd25,
    OP_RRCA  = 5'd26,
    OP_RLA   = 5'd27,
    OP_RRA   = 5'd28,
    OP_ADD16 = 5'd29,
    OP_ADDSP = 5'd30
  } alu_op_t;

  // Decimal adjust corrections and limits.
  localparam logic [7:0] DAA_HI_FIX   = 8'h60;
  localparam logic [7:0] DAA_LO_FIX   = 8'h06;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  typedef struct packed {
    logic carry;
    logic half;
    logic sub;
    logic zero;
  } flags_t;

  // One operation, laid out as on the input channel (lowest field last).
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    flags_t            flags;
    logic [2:0]        bit_index;
    logic [15:0]       operand_b;
    logic [15:0]       operand_a;
  } alu_in_t;

  // One result, laid out as on the output channel.
  typedef struct packed {
    logic        write_back;
    flags_t      flags;
    logic [15:0] result;
  } alu_out_t;

endpackage

// File: sv/cpu_alu_with_flags_core.sv
`timescale 1ns / 1ps

// Eight-bit processor ALU with zero, subtract, half carry and carry flags.
// An operation enters on the in_ channel: in_tuser carries the operation
// code, in_tdata the operands, the bit index and the incoming flags. The
// result, new flags and write-back flag leave on the out_ channel.
// out_tvalid rises once the operation has passed through one input register,
// the combinational datapath and one result register. With the receiver
// ready the block takes one operation every cycle; the rate is set by the
// two register slices, each of which refills in the cycle it empties.
// When the receiver stalls the result stays on out_tdata unchanged, and one
// further operation is held in the input register before in_tready drops.
// Reset (rst_n low, synchronous) empties both registers; nothing is kept
// from one operation to the next.
module cpu_alu_with_flags_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operand_a[15:0], operand_b[31:16], bit_index[34:32], zero_in[35],
  // sub_in[36], half_in[37], carry_in[38], zero fill[39]
  input  logic [cawf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[4:0]
  input  logic [cawf_pkg::FUNC_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result[15:0], zero_out[16], sub_out[17], half_out[18], carry_out[19],
  // write_back[20], zero fill[23:21]
  output logic [cawf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import cawf_pkg::*;

  alu_in_t  in_word;
  alu_in_t  op_q;
  alu_out_t res_d;
  alu_out_t res_q;
  logic     op_valid;
  logic     op_ready;

  // Unpack the input channel.
  assign in_word.func        = in_tuser;
  assign in_word.operand_a   = in_tdata[15:0];
  assign in_word.operand_b   = in_tdata[31:16];
  assign in_word.bit_index   = in_tdata[34:32];
  assign in_word.flags.zero  = in_tdata[35];
  assign in_word.flags.sub   = in_tdata[36];
  assign in_word.flags.half  = in_tdata[37];
  assign in_word.flags.carry = in_tdata[38];

  // Input register.
  cawf_stage #(
    .W($bits(alu_in_t))
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_word),
    .dn_valid (op_valid),
    .dn_ready (op_ready),
    .dn_data  (op_q)
  );

  // Datapath.
  cawf_alu u_alu (
    .op_i  (op_q),
    .res_o (res_d)
  );

  // Result register.
  cawf_stage #(
    .W($bits(alu_out_t))
  ) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (op_valid),
    .up_ready (op_ready),
    .up_data  (res_d),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res_q)
  );

  // Pack the output channel.
  assign out_tdata = {3'b000, res_q.write_back, res_q.flags.carry, res_q.flags.half,
                      res_q.flags.sub, res_q.flags.zero, res_q.result};

endmodule

// File: sv/cawf_stage.sv
`timescale 1ns / 1ps

// One register slice with valid/ready flow control. It takes a new word
// whenever it is empty or its content leaves in the same cycle.
module cawf_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic         valid_nxt;
  logic [W-1:0] data_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, loaded on every transfer in.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: sv/cawf_alu.sv
`timescale 1ns / 1ps

// Combinational datapath: result, flags and write-back for one operation.
module cawf_alu (
  input  cawf_pkg::alu_in_t  op_i,
  output cawf_pkg::alu_out_t res_o
);

  import cawf_pkg::*;

  alu_op_t     op;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  flags_t      fin;

  logic        t_adc;
  logic        t_sbc;
  logic [8:0]  add9;
  logic [4:0]  add_h5;
  logic [8:0]  sub9;
  logic [4:0]  sub_h5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  bit_mask;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_add;
  logic [7:0]  daa_sub;
  logic [16:0] add17;
  logic [12:0] add_h13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;

  logic [15:0] r;
  flags_t      fout;
  logic        wb;

  assign op  = alu_op_t'(op_i.func);
  assign a16 = op_i.operand_a;
  assign b16 = op_i.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];
  assign fin = op_i.flags;

  // Eight-bit add and subtract with nibble carries.
  assign t_adc  = (op == OP_ADC) && fin.carry;
  assign t_sbc  = (op == OP_SBC) && fin.carry;
  assign add9   = {1'b0, a} + {1'b0, b} + {8'h00, t_adc};
  assign add_h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t_adc};
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'h00, t_sbc};
  assign sub_h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t_sbc};
  assign inc8   = a + 8'd1;
  assign dec8   = a - 8'd1;

  assign bit_mask = 8'h01 << op_i.bit_index;

  // Decimal adjust after an addition or a subtraction.
  assign daa_hi  = fin.carry || (a > DAA_HI_LIMIT);
  assign daa_lo  = fin.half || (a[3:0] > DAA_LO_LIMIT);
  assign daa_add = a + (daa_hi ? DAA_HI_FIX : 8'h00) + (daa_lo ? DAA_LO_FIX : 8'h00);
  assign daa_sub = a - (fin.carry ? DAA_HI_FIX : 8'h00) - (fin.half ? DAA_LO_FIX : 8'h00);

  // Sixteen-bit add, and stack pointer plus signed offset.
  assign add17   = {1'b0, a16} + {1'b0, b16};
  assign add_h13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_sum  = a16 + {{8{b[7]}}, b};
  assign sp_h5   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_c9   = {1'b0, a16[7:0]} + {1'b0, b};

  // Operation select.
  always_comb begin
    r    = 16'h0000;
    fout = fin;
    wb   = 1'b1;
    case (op)
      OP_ADD, OP_ADC: begin
        r          = {8'h00, add9[7:0]};
        fout.zero  = (add9[7:0] == 8'h00);
        fout.sub   = 1'b0;
        fout.half  = add_h5[4];
        fout.carry = add9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r          = {8'h00, sub9[7:0]};
        fout.zero  = (sub9[7:0] == 8'h00);
        fout.sub   = 1'b1;
        fout.half  = sub_h5[4];
        fout.carry = sub9[8];
        wb         = (op != OP_CP);
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (op == OP_AND) begin
          r = {8'h00, a & b};
        end else if (op == OP_XOR) begin
          r = {8'h00, a ^ b};
        end else begin
          r = {8'h00, a | b};
        end
        fout.zero  = (r[7:0] == 8'h00);
        fout.sub   = 1'b0;
        fout.half  = (op == OP_AND);
        fout.carry = 1'b0;
      end
      OP_INC: begin
        r         = {8'h00, inc8};
        fout.zero = (inc8 == 8'h00);
        fout.sub  = 1'b0;
        fout.half = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r         = {8'h00, dec8};
        fout.zero = (dec8 == 8'h00);
        fout.sub  = 1'b1;
        fout.half = (a[3:0] == 4'h0);
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (op)
          OP_RLC, OP_RLCA: begin
            r          = {8'h00, a[6:0], a[7]};
            fout.carry = a[7];
          end
          OP_RRC, OP_RRCA: begin
            r          = {8'h00, a[0], a[7:1]};
            fout.carry = a[0];
          end
          OP_RL, OP_RLA: begin
            r          = {8'h00, a[6:0], fin.carry};
            fout.carry = a[7];
          end
          OP_RR, OP_RRA: begin
            r          = {8'h00, fin.carry, a[7:1]};
            fout.carry = a[0];
          end
          OP_SLA: begin
            r          = {8'h00, a[6:0], 1'b0};
            fout.carry = a[7];
          end
          OP_SRA: begin
            r          = {8'h00, a[7], a[7:1]};
            fout.carry = a[0];
          end
          OP_SWAP: begin
            r          = {8'h00, a[3:0], a[7:4]};
            fout.carry = 1'b0;
          end
          default: begin
            r          = {8'h00, 1'b0, a[7:1]};
            fout.carry = a[0];
          end
        endcase
        // The accumulator rotates always clear the zero flag.
        if (op inside {OP_RLCA, OP_RRCA, OP_RLA, OP_RRA}) begin
          fout.zero = 1'b0;
        end else begin
          fout.zero = (r[7:0] == 8'h00);
        end
        fout.sub  = 1'b0;
        fout.half = 1'b0;
      end
      OP_BIT: begin
        r         = {8'h00, a};
        wb        = 1'b0;
        fout.zero = ((a & bit_mask) == 8'h00);
        fout.sub  = 1'b0;
        fout.half = 1'b1;
      end
      OP_RES: begin
        r = {8'h00, a & ~bit_mask};
      end
      OP_SET: begin
        r = {8'h00, a | bit_mask};
      end
      OP_DAA: begin
        if (!fin.sub) begin
          r          = {8'h00, daa_add};
          fout.carry = fin.carry || daa_hi;
        end else begin
          r = {8'h00, daa_sub};
        end
        fout.zero = (r[7:0] == 8'h00);
        fout.half = 1'b0;
      end
      OP_CPL: begin
        r         = {8'h00, ~a};
        fout.sub  = 1'b1;
        fout.half = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        r          = {8'h00, a};
        wb         = 1'b0;
        fout.sub   = 1'b0;
        fout.half  = 1'b0;
        fout.carry = (op == OP_SCF) ? 1'b1 : !fin.carry;
      end
      OP_ADD16: begin
        r          = add17[15:0];
        fout.sub   = 1'b0;
        fout.half  = add_h13[12];
        fout.carry = add17[16];
      end
      OP_ADDSP: begin
        r          = sp_sum;
        fout.zero  = 1'b0;
        fout.sub   = 1'b0;
        fout.half  = sp_h5[4];
        fout.carry = sp_c9[8];
      end
      default: begin
        // Undefined code: no result, flags pass through.
        r  = 16'h0000;
        wb = 1'b0;
      end
    endcase
  end

  assign res_o.result     = r;
  assign res_o.flags      = fout;
  assign res_o.write_back = wb;

endmodule

// File: sv/cawf_checker.sv
`timescale 1ns / 1ps

`include "cpu_alu_with_flags_core_macros.svh"

// Port-level checks on the ALU core.
module cawf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cawf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds until it is taken.
  `CAWF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed or vanished")

  // Reset leaves no result pending.
  `CAWF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // A ready receiver never holds back the input side.
  `CAWF_ASSERT(a_no_false_stall, clk, rst_n, out_tready |-> in_tready, "input stalled with receiver ready")

  // An accepted operation reaches the output through both registers when not stalled.
  `CAWF_ASSERT(a_latency, clk, rst_n, (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid, "result missing two cycles after transfer")

endmodule

bind cpu_alu_with_flags_core cawf_checker u_cawf_checker (.*);

// File: tb/sv/cpu_alu_with_flags_core_tb.sv
`timescale 1ns / 1ps

module cpu_alu_with_flags_core_tb;
  import cawf_pkg::*;

  // Operation code with no defined function: flags pass, nothing is stored.
  localparam logic [FUNC_W-1:0] OP_UNUSED = 5'd31;

  // Incoming flag patterns, laid out as flags_t {carry, half, sub, zero}.
  localparam logic [3:0] FL_NONE = 4'b0000;
  localparam logic [3:0] FL_Z    = 4'b0001;
  localparam logic [3:0] FL_N    = 4'b0010;
  localparam logic [3:0] FL_H    = 4'b0100;
  localparam logic [3:0] FL_C    = 4'b1000;
  localparam logic [3:0] FL_ALL  = 4'b1111;

  // Cycles without any transfer before the run is abandoned.
  localparam int STALL_LIMIT    = 1000;
  localparam int RANDOM_OPS     = 1250;
  localparam int LONG_HOLD_OFF  = 60;
  localparam int HOLD_OFF_AT    = 300;
  localparam int DRAIN_AT       = 900;
  localparam int STEADY_FIRST   = 500;
  localparam int STEADY_LAST    = 699;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Both sides run without gaps while this is set.
  logic steady = 1'b0;
  int   results_seen = 0;
  int   idle_cycles = 0;

  cpu_alu_with_flags_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected outcome of one ALU operation.
  function automatic alu_out_t alu_compute(alu_in_t op);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        t;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
    alu_out_t    res;
    a = op.operand_a[7:0];
    b = op.operand_b[7:0];
    z = op.flags.zero;
    n = op.flags.sub;
    h = op.flags.half;
    c = op.flags.carry;
    v = 8'h00;
    res.result = 16'h0000;
    res.write_back = 1'b1;
    case (op.func)
      OP_ADD, OP_ADC: begin
        t = (op.func == OP_ADC) ? c : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
        v = sum9[7:0];
        h = nib[4];
        c = sum9[8];
        n = 1'b0;
        z = (v == 8'h00);
        res.result = {8'h00, v};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t = (op.func == OP_SBC) ? c : 1'b0;
        h = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, t}));
        c = ({1'b0, a} < ({1'b0, b} + {8'h00, t}));
        v = a - b - {7'h00, t};
        n = 1'b1;
        z = (v == 8'h00);
        res.result = {8'h00, v};
        res.write_back = (op.func != OP_CP);
      end
      OP_AND, OP_XOR, OP_OR: begin
        v = (op.func == OP_AND) ? (a & b) : (op.func == OP_XOR) ? (a ^ b) : (a | b);
        z = (v == 8'h00);
        n = 1'b0;
        h = (op.func == OP_AND);
        c = 1'b0;
        res.result = {8'h00, v};
      end
      OP_INC: begin
        v = a + 8'h01;
        z = (v == 8'h00);
        n = 1'b0;
        h = (a[3:0] == 4'hF);
        res.result = {8'h00, v};
      end
      OP_DEC: begin
        v = a - 8'h01;
        z = (v == 8'h00);
        n = 1'b1;
        h = (a[3:0] == 4'h0);
        res.result = {8'h00, v};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (op.func)
          OP_RLC, OP_RLCA: begin
            v = {a[6:0], a[7]};
            c = a[7];
          end
          OP_RRC, OP_RRCA: begin
            v = {a[0], a[7:1]};
            c = a[0];
          end
          OP_RL, OP_RLA: begin
            v = {a[6:0], c};
            c = a[7];
          end
          OP_RR, OP_RRA: begin
            v = {c, a[7:1]};
            c = a[0];
          end
          OP_SLA: begin
            v = {a[6:0], 1'b0};
            c = a[7];
          end
          OP_SRA: begin
            v = {a[7], a[7:1]};
            c = a[0];
          end
          OP_SWAP: begin
            v = {a[3:0], a[7:4]};
            c = 1'b0;
          end
          default: begin
            v = {1'b0, a[7:1]};
            c = a[0];
          end
        endcase
        // Accumulator rotates always clear the zero flag.
        z = (op.func >= OP_RLCA) ? 1'b0 : (v == 8'h00);
        n = 1'b0;
        h = 1'b0;
        res.result = {8'h00, v};
      end
      OP_BIT: begin
        res.result = {8'h00, a};
        res.write_back = 1'b0;
        z = ~a[op.bit_index];
        n = 1'b0;
        h = 1'b1;
      end
      OP_RES: begin
        v = a;
        v[op.bit_index] = 1'b0;
        res.result = {8'h00, v};
      end
      OP_SET: begin
        v = a;
        v[op.bit_index] = 1'b1;
        res.result = {8'h00, v};
      end
      OP_DAA: begin
        v = a;
        if (!n) begin
          if (c || a > DAA_HI_LIMIT) begin
            v = v + DAA_HI_FIX;
            c = 1'b1;
          end
          if (h || a[3:0] > DAA_LO_LIMIT) v = v + DAA_LO_FIX;
        end else begin
          if (c) v = v - DAA_HI_FIX;
          if (h) v = v - DAA_LO_FIX;
        end
        z = (v == 8'h00);
        h = 1'b0;
        res.result = {8'h00, v};
      end
      OP_CPL: begin
        res.result = {8'h00, ~a};
        n = 1'b1;
        h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        res.result = {8'h00, a};
        res.write_back = 1'b0;
        n = 1'b0;
        h = 1'b0;
        c = (op.func == OP_SCF) ? 1'b1 : ~c;
      end
      OP_ADD16: begin
        sum13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
        sum17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
        h = sum13[12];
        c = sum17[16];
        n = 1'b0;
        res.result = sum17[15:0];
      end
      OP_ADDSP: begin
        // Flags come from the unsigned add of the low byte and low nibble.
        res.result = op.operand_a + {{8{b[7]}}, b};
        nib = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, op.operand_a[7:0]} + {1'b0, b};
        h = nib[4];
        c = sum9[8];
        z = 1'b0;
        n = 1'b0;
      end
      default: begin
        res.write_back = 1'b0;
      end
    endcase
    res.flags.zero = z;
    res.flags.sub = n;
    res.flags.half = h;
    res.flags.carry = c;
    return res;
  endfunction

  // Holds the outcomes of operations taken in and not yet seen at the output.
  class alu_result_board;
    alu_out_t awaited_results[$];
    int       mismatches = 0;

    function void note_issued(alu_in_t op);
      awaited_results.push_back(alu_compute(op));
    endfunction

    function void check_retired(alu_out_t got);
      alu_out_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no operation outstanding: %h", got);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.result !== want.result) begin
        $error("result: expected %h, got %h", want.result, got.result);
        mismatches++;
      end
      if (got.flags.zero !== want.flags.zero) begin
        $error("zero_out: expected %b, got %b", want.flags.zero, got.flags.zero);
        mismatches++;
      end
      if (got.flags.sub !== want.flags.sub) begin
        $error("sub_out: expected %b, got %b", want.flags.sub, got.flags.sub);
        mismatches++;
      end
      if (got.flags.half !== want.flags.half) begin
        $error("half_out: expected %b, got %b", want.flags.half, got.flags.half);
        mismatches++;
      end
      if (got.flags.carry !== want.flags.carry) begin
        $error("carry_out: expected %b, got %b", want.flags.carry, got.flags.carry);
        mismatches++;
      end
      if (got.write_back !== want.write_back) begin
        $error("write_back: expected %b, got %b", want.write_back, got.write_back);
        mismatches++;
      end
    endfunction
  endclass

  alu_result_board board = new();

  function automatic alu_in_t make_op(logic [FUNC_W-1:0] f, logic [15:0] a, logic [15:0] b,
                                      logic [2:0] bi, logic [3:0] fl);
    alu_in_t op;
    op.func = f;
    op.operand_a = a;
    op.operand_b = b;
    op.bit_index = bi;
    op.flags = flags_t'(fl);
    return op;
  endfunction

  // Random operation, biased towards byte boundaries and carry edges.
  function automatic alu_in_t random_op();
    logic [7:0] edges [8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A};
    alu_in_t    op;
    alu_in_t    pre;
    alu_out_t   pre_res;
    op.func = ($urandom_range(0, 63) == 0) ? OP_UNUSED : 5'($urandom_range(0, 30));
    op.operand_a = 16'($urandom);
    op.operand_b = 16'($urandom);
    op.bit_index = 3'($urandom_range(0, 7));
    op.flags = flags_t'(4'($urandom_range(0, 15)));
    if ($urandom_range(0, 3) == 0) op.operand_a[7:0] = edges[$urandom_range(0, 7)];
    if ($urandom_range(0, 3) == 0) op.operand_b[7:0] = edges[$urandom_range(0, 7)];
    if ($urandom_range(0, 7) == 0) op.operand_b[7:0] = op.operand_a[7:0];
    if ($urandom_range(0, 7) == 0) op.operand_a[15:8] = edges[$urandom_range(0, 7)];
    // Most decimal adjusts follow a real BCD add or subtract.
    if (op.func == OP_DAA && $urandom_range(0, 2) != 0) begin
      pre = make_op(5'($urandom_range(0, 1)) + (($urandom_range(0, 1) == 1) ? OP_SUB : OP_ADD),
                    {8'h00, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
                    {8'h00, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
                    3'd0, 4'($urandom_range(0, 15)));
      pre_res = alu_compute(pre);
      op.operand_a[7:0] = pre_res.result[7:0];
      op.flags = pre_res.flags;
    end
    return op;
  endfunction

  // Offer one operation after a random gap and wait for its transfer.
  task automatic issue_op(input alu_in_t op);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, op.flags, op.bit_index, op.operand_b, op.operand_a};
    in_tuser = op.func;
    do @(posedge clk); while (!in_tready);
    board.note_issued(op);
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off to fill the block.
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (!held_off && results_seen == HOLD_OFF_AT) begin
        held_off = 1'b1;
        stall = LONG_HOLD_OFF;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_retired(alu_out_t'(out_tdata[20:0]));
      results_seen++;
      @(negedge clk);
    end
  end

  // Watchdog on cycles in which neither side completes a transfer.
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus and final verdict.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: each operation once, plus carry and half-carry edges.
    issue_op(make_op(OP_ADD, 16'h00FF, 16'h0001, 3'd0, FL_NONE));
    issue_op(make_op(OP_ADC, 16'h000F, 16'h0000, 3'd0, FL_C));
    issue_op(make_op(OP_SUB, 16'h0000, 16'h0001, 3'd0, FL_NONE));
    issue_op(make_op(OP_SBC, 16'h0010, 16'h000F, 3'd0, FL_C));
    issue_op(make_op(OP_AND, 16'h00F0, 16'h000F, 3'd0, FL_ALL));
    issue_op(make_op(OP_XOR, 16'hFFA5, 16'hFFA5, 3'd0, FL_NONE));
    issue_op(make_op(OP_OR, 16'h0000, 16'h0000, 3'd0, FL_ALL));
    issue_op(make_op(OP_CP, 16'h0042, 16'h0042, 3'd0, FL_NONE));
    issue_op(make_op(OP_INC, 16'h00FF, 16'h0000, 3'd0, FL_N));
    issue_op(make_op(OP_DEC, 16'h0010, 16'h0000, 3'd0, FL_H));
    issue_op(make_op(OP_RLC, 16'h0080, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_RRC, 16'h0001, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_RL, 16'h0080, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_RR, 16'h0001, 16'h0000, 3'd0, FL_C));
    issue_op(make_op(OP_SLA, 16'h0080, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_SRA, 16'h0081, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_SWAP, 16'h00F0, 16'h0000, 3'd0, FL_C));
    issue_op(make_op(OP_SRL, 16'h0001, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_BIT, 16'h007F, 16'h0000, 3'd7, FL_C));
    issue_op(make_op(OP_RES, 16'h00FF, 16'h0000, 3'd0, FL_ALL));
    issue_op(make_op(OP_SET, 16'hFF00, 16'h0000, 3'd7, FL_NONE));
    issue_op(make_op(OP_DAA, 16'h009A, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_DAA, 16'h0000, 16'h0000, 3'd0, FL_N | FL_H | FL_C));
    issue_op(make_op(OP_CPL, 16'h0000, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_SCF, 16'h0055, 16'h0000, 3'd0, FL_ALL));
    issue_op(make_op(OP_CCF, 16'h00AA, 16'h0000, 3'd0, FL_C));
    issue_op(make_op(OP_RLCA, 16'h0000, 16'h0000, 3'd0, FL_Z));
    issue_op(make_op(OP_RRCA, 16'h0001, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_RLA, 16'h0080, 16'h0000, 3'd0, FL_NONE));
    issue_op(make_op(OP_RRA, 16'h0001, 16'h0000, 3'd0, FL_C));
    issue_op(make_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, FL_Z));
    issue_op(make_op(OP_ADDSP, 16'hFFFF, 16'h0001, 3'd0, FL_ALL));
    issue_op(make_op(OP_ADDSP, 16'h0000, 16'h0080, 3'd0, FL_NONE));
    issue_op(make_op(OP_UNUSED, 16'h1234, 16'h5678, 3'd3, FL_ALL));

    // Random part, with a gap-free stretch and one full drain midway.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      steady = (i >= STEADY_FIRST && i <= STEADY_LAST);
      if (i == DRAIN_AT) begin
        in_tvalid = 1'b0;
        while (board.awaited_results.size() != 0) @(negedge clk);
      end
      issue_op(random_op());
    end
    steady = 1'b0;
    in_tvalid = 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.awaited_results.size() != 0) begin
      $error("%0d results never arrived", board.awaited_results.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
